@@ rtl/core/slrp_pkg.sv @@
package slrp_pkg;

    // pool geometry
    localparam int POOL_SIZE   = 16;
    localparam int CITY_CHARS  = 8;
    localparam int NAME_CHARS  = 8;
    localparam int MAX_RESULTS = 16;

    localparam int ADDR_W = $clog2(POOL_SIZE);
    localparam int IDX_W  = $clog2(POOL_SIZE + 1);
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    // null link is coded as POOL_SIZE
    localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(POOL_SIZE);

    localparam int KEY_W  = 64;
    localparam int SEX_W  = 8;
    localparam int REC_W  = 2 * KEY_W + SEX_W;
    localparam int DATA_W = ((REC_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_PUSH    = 2'd0,
        KIND_POP     = 2'd1,
        KIND_INSERT  = 2'd2,
        KIND_EXTRACT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NO_MATCH = 2'd3
    } status_t;

    // keep the first chars bytes, clear everything from the first zero byte on
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] v, input int chars);
        logic [KEY_W-1:0] r;
        logic             stop;
        int               i;
        r    = '0;
        stop = 1'b0;
        for (i = 0; i < 8; i++) begin
            if (i >= chars || v[KEY_W-8-8*i +: 8] == 8'h00) stop = 1'b1;
            if (!stop) r[KEY_W-8-8*i +: 8] = v[KEY_W-8-8*i +: 8];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/slrp_ram.sv @@
// simple dual-port RAM, registered read
module slrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/sorted_linked_record_pool_core.sv @@
// Pool of POOL_SIZE nodes holding one linked list of person records (city,
// name, sex byte); unused nodes sit on a free list. s_tuser picks the
// operation: push at the top, pop the top record, sorted insert before the
// first node whose city is not smaller, or extract every record whose city
// equals the key. Keys are cut to 8 bytes and cleared from the first zero
// byte before storing and comparing. Each operation gives one or more result
// words on the m_ side; m_tuser carries the status and m_tlast marks the
// final word of the operation. Extracted records come out in the reverse of
// their list order. The core takes one word at a time: s_tready is high only
// between operations. Every operation passes through a start state; push,
// pop and a failing push, insert or pop then go to the reply or pop state,
// which loads the result into the output register. Sorted insert first walks
// the list node by node up to its slot, then replies. Extract walks every node,
// unlinking matches, sees the end of the list, then either replies no match or
// frees each extracted node in turn, loading a word for each of the first
// MAX_RESULTS. The node store has one read port and is walked one node per
// cycle, with the city comparisons on its read data shared by insert and
// extract. Link words sit in flip-flops, so there is no clearing pass after
// reset. Back pressure on m_tready holds the pop, reply and extract output
// states until the output register is free.
module sorted_linked_record_pool_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [slrp_pkg::DATA_W-1:0]   s_tdata,  // city_key, person_name, sex_code
    input  logic [1:0]                    s_tuser,  // kind
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [slrp_pkg::DATA_W-1:0]   m_tdata,  // out_city, out_name, out_sex
    output logic [1:0]                    m_tuser,  // status
    output logic                          m_tlast   // last
);

    localparam int KW = slrp_pkg::KEY_W;
    localparam int SW = slrp_pkg::SEX_W;
    localparam int AW = slrp_pkg::ADDR_W;
    localparam int IW = slrp_pkg::IDX_W;
    localparam int CW = slrp_pkg::CNT_W;
    localparam int RW = slrp_pkg::REC_W;
    localparam int DW = slrp_pkg::DATA_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_INS   = 7'b0000100,   // insert: walk to the slot
        S_POP   = 7'b0001000,
        S_EXW   = 7'b0010000,   // extract: unlink matches
        S_EXO   = 7'b0100000,   // extract: emit and free
        S_REPLY = 7'b1000000    // status-only word
    } state_t;

    function automatic logic is_node(input logic [IW-1:0] x);
        return x < IW'(slrp_pkg::POOL_SIZE);
    endfunction

    state_t              state_reg,     state_next;
    slrp_pkg::kind_t     kind_reg,      kind_next;
    slrp_pkg::status_t   reply_reg,     reply_next;
    logic [KW-1:0]       city_reg,      city_next;
    logic [KW-1:0]       name_reg,      name_next;
    logic [SW-1:0]       sex_reg,       sex_next;
    logic [IW-1:0]       cur_reg,       cur_next;
    logic [IW-1:0]       prev_reg,      prev_next;
    logic [IW-1:0]       ehead_reg,     ehead_next;
    logic [IW-1:0]       node_reg,      node_next;
    logic [IW-1:0]       free_head_reg, free_head_next;
    logic [IW-1:0]       top_reg,       top_next;
    logic [CW-1:0]       cnt_reg,       cnt_next;

    logic                m_tvalid_reg,  m_tvalid_next;
    logic [DW-1:0]       m_tdata_reg,   m_tdata_next;
    logic [1:0]          m_tuser_reg,   m_tuser_next;
    logic                m_tlast_reg,   m_tlast_next;

    // link words, one read address and two write ports
    logic [IW-1:0]       link_reg [slrp_pkg::POOL_SIZE];
    logic [IW-1:0]       lk_raddr;
    logic [IW-1:0]       lk_rdata;
    logic                lka_en,   lkb_en;
    logic [IW-1:0]       lka_addr, lkb_addr;
    logic [IW-1:0]       lka_data, lkb_data;

    // node store
    logic                ram_we;
    logic [RW-1:0]       ram_rdata;
    logic [KW-1:0]       rd_city;
    logic [KW-1:0]       rd_name;
    logic [SW-1:0]       rd_sex;

    // shared city comparator
    logic                city_lt, city_eq;
    logic                out_free;

    slrp_ram #(
        .WIDTH (RW),
        .DEPTH (slrp_pkg::POOL_SIZE)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_head_reg[AW-1:0]),
        .wdata ({sex_reg, name_reg, city_reg}),
        .raddr (cur_next[AW-1:0]),   // registered read, so the read data belongs to cur_reg
        .rdata (ram_rdata)
    );

    assign rd_city = ram_rdata[KW-1:0];
    assign rd_name = ram_rdata[2*KW-1:KW];
    assign rd_sex  = ram_rdata[RW-1:2*KW];

    assign city_lt = rd_city < city_reg;
    assign city_eq = rd_city == city_reg;

    assign lk_rdata = link_reg[lk_raddr[AW-1:0]];
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        reply_next     = reply_reg;
        city_next      = city_reg;
        name_next      = name_reg;
        sex_next       = sex_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        ehead_next     = ehead_reg;
        node_next      = node_reg;
        free_head_next = free_head_reg;
        top_next       = top_reg;
        cnt_next       = cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        lk_raddr       = cur_reg;
        lka_en         = 1'b0;
        lka_addr       = cur_reg;
        lka_data       = free_head_reg;
        lkb_en         = 1'b0;
        lkb_addr       = prev_reg;
        lkb_data       = node_reg;
        ram_we         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = slrp_pkg::kind_t'(s_tuser);
                    city_next  = slrp_pkg::norm_key(s_tdata[KW-1:0], slrp_pkg::CITY_CHARS);
                    name_next  = slrp_pkg::norm_key(s_tdata[2*KW-1:KW], slrp_pkg::NAME_CHARS);
                    sex_next   = s_tdata[RW-1:2*KW];
                    state_next = S_START;
                end
            end

            S_START: begin
                lk_raddr = free_head_reg;
                case (kind_reg)
                    slrp_pkg::KIND_PUSH, slrp_pkg::KIND_INSERT: begin
                        if (!is_node(free_head_reg)) begin
                            reply_next = slrp_pkg::ST_FULL;
                            state_next = S_REPLY;
                        end else begin
                            // take the free head and store the record there
                            node_next      = free_head_reg;
                            free_head_next = lk_rdata;
                            ram_we         = 1'b1;
                            if (kind_reg == slrp_pkg::KIND_PUSH) begin
                                lka_en     = 1'b1;
                                lka_addr   = free_head_reg;
                                lka_data   = top_reg;
                                top_next   = free_head_reg;
                                reply_next = slrp_pkg::ST_OK;
                                state_next = S_REPLY;
                            end else begin
                                prev_next  = slrp_pkg::NIL_IDX;
                                cur_next   = top_reg;
                                state_next = S_INS;
                            end
                        end
                    end
                    slrp_pkg::KIND_POP: begin
                        if (!is_node(top_reg)) begin
                            reply_next = slrp_pkg::ST_EMPTY;
                            state_next = S_REPLY;
                        end else begin
                            cur_next   = top_reg;
                            state_next = S_POP;
                        end
                    end
                    slrp_pkg::KIND_EXTRACT: begin
                        prev_next  = slrp_pkg::NIL_IDX;
                        ehead_next = slrp_pkg::NIL_IDX;
                        cur_next   = top_reg;
                        state_next = S_EXW;
                    end
                    default: state_next = S_IDLE;
                endcase
            end

            S_INS: begin
                if (!is_node(cur_reg) || !city_lt) begin
                    // splice the new node in before cur
                    lka_en   = 1'b1;
                    lka_addr = node_reg;
                    lka_data = cur_reg;
                    if (is_node(prev_reg)) begin
                        lkb_en   = 1'b1;
                        lkb_addr = prev_reg;
                        lkb_data = node_reg;
                    end else begin
                        top_next = node_reg;
                    end
                    reply_next = slrp_pkg::ST_OK;
                    state_next = S_REPLY;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = lk_rdata;
                end
            end

            S_POP: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = DW'({rd_sex, rd_name, rd_city});
                    m_tuser_next   = slrp_pkg::ST_OK;
                    m_tlast_next   = 1'b1;
                    top_next       = lk_rdata;
                    lka_en         = 1'b1;   // back onto the free list
                    free_head_next = cur_reg;
                    state_next     = S_IDLE;
                end
            end

            S_EXW: begin
                if (!is_node(cur_reg)) begin
                    if (!is_node(ehead_reg)) begin
                        reply_next = slrp_pkg::ST_NO_MATCH;
                        state_next = S_REPLY;
                    end else begin
                        cur_next   = ehead_reg;
                        cnt_next   = '0;
                        state_next = S_EXO;
                    end
                end else begin
                    if (city_eq) begin
                        // unlink cur and push it onto the extracted chain
                        if (is_node(prev_reg)) begin
                            lkb_en   = 1'b1;
                            lkb_addr = prev_reg;
                            lkb_data = lk_rdata;
                        end else begin
                            top_next = lk_rdata;
                        end
                        lka_en     = 1'b1;
                        lka_data   = ehead_reg;
                        ehead_next = cur_reg;
                    end else begin
                        prev_next = cur_reg;
                    end
                    cur_next = lk_rdata;
                end
            end

            S_EXO: begin
                if (cnt_reg < CW'(slrp_pkg::MAX_RESULTS)) begin
                    if (out_free) begin
                        m_tvalid_next  = 1'b1;
                        m_tdata_next   = DW'({rd_sex, rd_name, rd_city});
                        m_tuser_next   = slrp_pkg::ST_OK;
                        m_tlast_next   = !is_node(lk_rdata) ||
                                         cnt_reg == CW'(slrp_pkg::MAX_RESULTS - 1);
                        cnt_next       = cnt_reg + 1'b1;
                        lka_en         = 1'b1;
                        free_head_next = cur_reg;
                        cur_next       = lk_rdata;
                        if (!is_node(lk_rdata)) state_next = S_IDLE;
                    end
                end else begin
                    // past the word limit: free silently
                    lka_en         = 1'b1;
                    free_head_next = cur_reg;
                    cur_next       = lk_rdata;
                    if (!is_node(lk_rdata)) state_next = S_IDLE;
                end
            end

            S_REPLY: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = reply_reg;
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= IW'(slrp_pkg::POOL_SIZE - 1);
            top_reg       <= slrp_pkg::NIL_IDX;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            top_reg       <= top_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        reply_reg   <= reply_next;
        city_reg    <= city_next;
        name_reg    <= name_next;
        sex_reg     <= sex_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        ehead_reg   <= ehead_next;
        node_reg    <= node_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // link words: after reset each entry points one lower, entry 0 to null
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < slrp_pkg::POOL_SIZE; i++) begin
                link_reg[i] <= (i == 0) ? slrp_pkg::NIL_IDX : IW'(i - 1);
            end
        end else begin
            if (lka_en) link_reg[lka_addr[AW-1:0]] <= lka_data;
            if (lkb_en) link_reg[lkb_addr[AW-1:0]] <= lkb_data;
        end
    end

endmodule

@@ tb/sv/sorted_linked_record_pool_core_test.sv @@
module sorted_linked_record_pool_core_test;

    localparam int LIMIT_CYCLES = 400000;

    localparam int KEY_W       = slrp_pkg::KEY_W;
    localparam int SEX_W       = slrp_pkg::SEX_W;
    localparam int DATA_W      = slrp_pkg::DATA_W;
    localparam int IDX_W       = slrp_pkg::IDX_W;
    localparam int POOL_SIZE   = slrp_pkg::POOL_SIZE;
    localparam int CITY_CHARS  = slrp_pkg::CITY_CHARS;
    localparam int NAME_CHARS  = slrp_pkg::NAME_CHARS;
    localparam int MAX_RESULTS = slrp_pkg::MAX_RESULTS;
    localparam logic [IDX_W-1:0] NIL_IDX = slrp_pkg::NIL_IDX;

    // one result word as the predictor sees it
    typedef struct packed {
        slrp_pkg::status_t  status;
        logic [KEY_W-1:0]   city;
        logic [KEY_W-1:0]   name;
        logic [SEX_W-1:0]   sex;
        logic               is_last;
    } rec_result_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata  = '0;
    logic [1:0]          s_tuser  = slrp_pkg::KIND_PUSH;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    // predictor state: link words, node contents, free list and list heads
    logic [IDX_W-1:0]    pool_link [POOL_SIZE];
    logic [KEY_W-1:0]    pool_city [POOL_SIZE];
    logic [KEY_W-1:0]    pool_name [POOL_SIZE];
    logic [SEX_W-1:0]    pool_sex  [POOL_SIZE];
    logic [IDX_W-1:0]    free_head;
    logic [IDX_W-1:0]    list_top;

    rec_result_t         pending_results [$];
    rec_result_t         want;
    logic [KEY_W-1:0]    city_tab [4];
    int                  fault_cnt     = 0;
    int                  cycle_cnt     = 0;
    int                  src_idle_pct  = 0;
    int                  snk_stall_pct = 0;

    sorted_linked_record_pool_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // runaway guard
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("FAIL sorted_linked_record_pool_core");
            $finish;
        end
    end

    // receiver back pressure, one draw per cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // keep the leading chars bytes, stop at the first zero byte
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw,
                                                  input int chars);
        logic [KEY_W-1:0] kept;
        logic             done;
        int               b;
        kept = '0;
        done = 1'b0;
        for (b = 0; b < 8; b++) begin
            if (b >= chars || raw[KEY_W-8-8*b +: 8] == 8'h00) done = 1'b1;
            if (!done) kept[KEY_W-8-8*b +: 8] = raw[KEY_W-8-8*b +: 8];
        end
        return kept;
    endfunction

    function automatic void add_result(input slrp_pkg::status_t st,
                                       input logic [KEY_W-1:0] c,
                                       input logic [KEY_W-1:0] n,
                                       input logic [SEX_W-1:0] s, input logic lst);
        rec_result_t r;
        r.status  = st;
        r.city    = c;
        r.name    = n;
        r.sex     = s;
        r.is_last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void clear_pool_model();
        int i;
        for (i = 0; i < POOL_SIZE; i++) begin
            pool_link[i] = (i == 0) ? NIL_IDX : IDX_W'(i - 1);
            pool_city[i] = '0;
            pool_name[i] = '0;
            pool_sex[i]  = '0;
        end
        free_head = IDX_W'(POOL_SIZE - 1);
        list_top  = NIL_IDX;
    endfunction

    // applies one accepted word to the model and queues the words it should give
    function automatic void apply_record_op(input slrp_pkg::kind_t op,
                                            input logic [KEY_W-1:0] city_raw,
                                            input logic [KEY_W-1:0] name_raw,
                                            input logic [SEX_W-1:0] sex);
        logic [KEY_W-1:0] city;
        logic [KEY_W-1:0] name;
        logic [IDX_W-1:0] n, cur, prev, nxt, ehead;
        int               cnt;
        city = trim_key(city_raw, CITY_CHARS);
        name = trim_key(name_raw, NAME_CHARS);
        case (op)
            slrp_pkg::KIND_PUSH, slrp_pkg::KIND_INSERT: begin
                if (free_head == NIL_IDX) begin
                    add_result(slrp_pkg::ST_FULL, '0, '0, '0, 1'b1);
                end else begin
                    n         = free_head;
                    free_head = pool_link[n];
                    pool_city[n] = city;
                    pool_name[n] = name;
                    pool_sex[n]  = sex;
                    prev = NIL_IDX;
                    cur  = list_top;
                    if (op == slrp_pkg::KIND_INSERT) begin
                        while (cur != NIL_IDX && pool_city[cur] < city) begin
                            prev = cur;
                            cur  = pool_link[cur];
                        end
                    end
                    pool_link[n] = cur;
                    if (prev != NIL_IDX) pool_link[prev] = n;
                    else list_top = n;
                    add_result(slrp_pkg::ST_OK, '0, '0, '0, 1'b1);
                end
            end
            slrp_pkg::KIND_POP: begin
                n = list_top;
                if (n == NIL_IDX) begin
                    add_result(slrp_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
                end else begin
                    list_top = pool_link[n];
                    add_result(slrp_pkg::ST_OK, pool_city[n], pool_name[n], pool_sex[n],
                               1'b1);
                    pool_link[n] = free_head;
                    free_head    = n;
                end
            end
            default: begin
                // unlink matches onto a private chain, newest first
                ehead = NIL_IDX;
                prev  = NIL_IDX;
                cur   = list_top;
                while (cur != NIL_IDX) begin
                    nxt = pool_link[cur];
                    if (pool_city[cur] == city) begin
                        if (prev != NIL_IDX) pool_link[prev] = nxt;
                        else list_top = nxt;
                        pool_link[cur] = ehead;
                        ehead = cur;
                    end else begin
                        prev = cur;
                    end
                    cur = nxt;
                end
                if (ehead == NIL_IDX) begin
                    add_result(slrp_pkg::ST_NO_MATCH, '0, '0, '0, 1'b1);
                end else begin
                    cnt = 0;
                    cur = ehead;
                    while (cur != NIL_IDX) begin
                        nxt = pool_link[cur];
                        if (cnt < MAX_RESULTS) begin
                            add_result(slrp_pkg::ST_OK, pool_city[cur], pool_name[cur],
                                       pool_sex[cur], 1'b0);
                            cnt++;
                        end
                        pool_link[cur] = free_head;
                        free_head      = cur;
                        cur = nxt;
                    end
                    pending_results[$].is_last = 1'b1;
                end
            end
        endcase
    endfunction

    // random key, now and then with a zero byte somewhere inside
    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] v;
        int               k;
        v = {$urandom, $urandom};
        k = $urandom_range(7);
        if ($urandom_range(3) == 0) v[8*k +: 8] = 8'h00;
        return v;
    endfunction

    // fill the bytes after the first zero with junk; the key still normalises the same
    function automatic logic [KEY_W-1:0] garble_tail(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] r;
        logic             hit;
        int               i;
        r   = v;
        hit = 1'b0;
        for (i = 7; i >= 0; i--) begin
            if (hit) r[8*i +: 8] = 8'($urandom);
            else if (v[8*i +: 8] == 8'h00) hit = 1'b1;
        end
        return r;
    endfunction

    // one input word; tvalid is left high after acceptance so back-to-back words
    // never see a low-then-high in the same step
    task automatic send_word(input slrp_pkg::kind_t op, input logic [KEY_W-1:0] city,
                             input logic [KEY_W-1:0] name, input logic [SEX_W-1:0] sex);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sex, name, city};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        apply_record_op(op, city, name, sex);
    endtask

    // sender holds off until every queued result word has arrived
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // pop and extract on an empty list
    task automatic test_empty_list();
        send_word(slrp_pkg::KIND_POP, rand_key(), rand_key(), 8'($urandom));
        send_word(slrp_pkg::KIND_EXTRACT, 64'h4E4F_4E45_0000_0000, rand_key(), 8'($urandom));
    endtask

    // all-ones and all-zero records, a key with junk after its terminator
    task automatic test_field_extremes();
        send_word(slrp_pkg::KIND_PUSH, '1, '1, 8'hFF);
        send_word(slrp_pkg::KIND_PUSH, '0, '0, 8'h00);
        // "A" then junk, name "MARIA" then junk; lands between the zero and all-ones cities
        send_word(slrp_pkg::KIND_INSERT, 64'h4100_5A5A_5A5A_5A5A, 64'h4D41_5249_4100_FFFF,
                  8'h46);
        send_word(slrp_pkg::KIND_POP, rand_key(), rand_key(), 8'($urandom));
        send_word(slrp_pkg::KIND_POP, rand_key(), rand_key(), 8'($urandom));
    endtask

    // fill by sorted insert, hit the full pool both ways, then extract one city and one absent city
    task automatic test_pool_full();
        logic [KEY_W-1:0] cities [3];
        int               i;
        cities[0] = 64'h4241_5345_4C00_0000;   // BASEL
        cities[1] = 64'h4C59_4F4E_0000_0000;   // LYON
        cities[2] = 64'h544F_5552_5300_0000;   // TOURS
        for (i = 0; i < POOL_SIZE - 1; i++) begin
            send_word(slrp_pkg::KIND_INSERT, cities[(i * 2) % 3],
                      {56'h50_4552_534F_4E5F, 8'(8'h41 + i)},
                      8'(i % 2 ? 8'h46 : 8'h4D));
        end
        send_word(slrp_pkg::KIND_PUSH, rand_key(), rand_key(), 8'($urandom));
        send_word(slrp_pkg::KIND_INSERT, rand_key(), rand_key(), 8'($urandom));
        send_word(slrp_pkg::KIND_EXTRACT, garble_tail(cities[1]), rand_key(), 8'($urandom));
        send_word(slrp_pkg::KIND_EXTRACT, 64'h5A55_5249_4348_0000, rand_key(), 8'($urandom));
    endtask

    // random mix weighted towards growth so the pool keeps filling and emptying
    task automatic test_random_ops(input int count, input int idle_pct, input int stall_pct);
        slrp_pkg::kind_t  op;
        logic [KEY_W-1:0] city;
        int               i, r;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        for (i = 0; i < 4; i++) city_tab[i] = rand_key();
        for (i = 0; i < count; i++) begin
            r  = $urandom_range(99);
            op = (r < 25) ? slrp_pkg::KIND_PUSH :
                 (r < 60) ? slrp_pkg::KIND_INSERT :
                 (r < 75) ? slrp_pkg::KIND_POP : slrp_pkg::KIND_EXTRACT;
            if ($urandom_range(99) < 75) begin
                city = city_tab[$urandom_range(3)];
                if ($urandom_range(1) == 1) city = garble_tail(city);
            end else begin
                city = rand_key();
            end
            send_word(op, city, rand_key(), 8'($urandom));
        end
    endtask

    // result checker: compare each accepted word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("unexpected result word: status %0d data %h last %b",
                             m_tuser, m_tdata, m_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status || m_tdata[63:0] !== want.city ||
                    m_tdata[127:64] !== want.name || m_tdata[135:128] !== want.sex ||
                    m_tlast !== want.is_last) begin
                    fault_cnt++;
                    if (fault_cnt <= 10) begin
                        $display("mismatch: exp status %0d city %h name %h sex %h last %b",
                                 want.status, want.city, want.name, want.sex, want.is_last);
                        $display("          got status %0d city %h name %h sex %h last %b",
                                 m_tuser, m_tdata[63:0], m_tdata[127:64],
                                 m_tdata[135:128], m_tlast);
                    end
                end
            end
        end
    end

    initial begin
        clear_pool_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        test_field_extremes();
        test_pool_full();
        wait_for_results();

        test_random_ops(26, 0, 0);
        wait_for_results();
        test_random_ops(26, 81, 0);
        wait_for_results();
        test_random_ops(26, 0, 81);
        wait_for_results();
        test_random_ops(26, 26, 26);
        wait_for_results();

        // let any stray trailing word show up
        repeat (64) @(posedge aclk);
        if (fault_cnt == 0 && pending_results.size() == 0) begin
            $display("PASS sorted_linked_record_pool_core");
        end else begin
            $display("FAIL sorted_linked_record_pool_core");
        end
        $finish;
    end

endmodule
